// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ERTU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Concurrent assertion that also holds across reset.
`define ERTU_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error(msg);

`endif

// ----- rtl/ertu_pkg.sv -----
// ----------------------------------------------------------------------------
// ertu_pkg
// Types and constants of the pose transform unit: beat layouts, fixed-point
// widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package ertu_pkg;

   localparam int COORD_IN_W  = 32;  // Q16.16 coordinates at the ports
   localparam int ANGLE_W     = 16;  // binary angle, 2^16 units per turn
   localparam int ANGLE_SHIFT = 16;  // scales the angle to 2^32 per turn
   localparam int TRIG_W      = 32;  // sine and cosine in Q2.30
   localparam int TRIG_FRAC   = 30;
   localparam int COORD_W     = 34;  // rotated coordinates, norm below 2^33
   localparam int RESID_W     = 34;  // CORDIC angle residual
   localparam int ATAN_W      = 30;
   localparam int ATAN_LEN    = 32;

   // Limit of the CORDIC gain correction in Q2.30.
   localparam logic signed [TRIG_W-1:0] CORDIC_INIT = 32'sd652032874;

   // atan(2^-i) with 2^32 units per turn.
   localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
      30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
      30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
      30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D,
      30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
      30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
      30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005,
      30'h00000003, 30'h00000001, 30'h00000001, 30'h00000000
   };

   typedef struct packed {
      logic signed [COORD_IN_W-1:0] point_x;
      logic signed [COORD_IN_W-1:0] point_y;
      logic signed [COORD_IN_W-1:0] point_z;
      logic signed [COORD_IN_W-1:0] offset_x;
      logic signed [COORD_IN_W-1:0] offset_y;
      logic signed [COORD_IN_W-1:0] offset_z;
      logic signed [ANGLE_W-1:0]    roll_angle;
      logic signed [ANGLE_W-1:0]    pitch_angle;
      logic signed [ANGLE_W-1:0]    yaw_angle;
   } ertu_req_type;

   typedef struct packed {
      logic signed [COORD_IN_W-1:0] out_x;
      logic signed [COORD_IN_W-1:0] out_y;
      logic signed [COORD_IN_W-1:0] out_z;
   } ertu_rsp_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_val;
      logic signed [TRIG_W-1:0] cos_val;
   } ertu_trig_type;

endpackage

`default_nettype wire

// ----- rtl/ertu_cordic.sv -----
// ----------------------------------------------------------------------------
// ertu_cordic
// Unrolled rotation-mode CORDIC giving sine and cosine of a binary angle,
// one register stage per iteration plus a fold stage and an output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ertu_cordic #(
   parameter int STAGES = 16
) (
   input  wire                                     clock,
   input  wire                                     enable,
   input  wire signed [ertu_pkg::ANGLE_W-1:0]      angle,
   output ertu_pkg::ertu_trig_type                 trig
);

   localparam int ANGLE_W   = ertu_pkg::ANGLE_W;
   localparam int TRIG_W    = ertu_pkg::TRIG_W;
   localparam int RESID_W   = ertu_pkg::RESID_W;
   localparam int EXT_W     = ANGLE_W + 1;
   localparam int PAD_W     = RESID_W - EXT_W - ertu_pkg::ANGLE_SHIFT;

   localparam logic signed [ANGLE_W-1:0] QUARTER     = 16'sh4000;
   localparam logic signed [ANGLE_W-1:0] NEG_QUARTER = 16'shC000;
   localparam logic signed [EXT_W-1:0]   HALF_EXT    = 17'sh08000;

   logic signed [TRIG_W-1:0]  x_ff [0:STAGES];
   logic signed [TRIG_W-1:0]  y_ff [0:STAGES];
   logic signed [RESID_W-1:0] z_ff [0:STAGES];
   logic                      neg_ff [0:STAGES];

   logic signed [EXT_W-1:0]   angle_ext;
   logic signed [EXT_W-1:0]   fold_val;
   logic                      fold_neg;
   ertu_pkg::ertu_trig_type   trig_ff;

   // Angles beyond a quarter turn are folded by half a turn; the result is
   // negated at the end to make up for it.
   always_comb begin
      angle_ext = {angle[ANGLE_W-1], angle};
      fold_val  = angle_ext;
      fold_neg  = 1'b0;
      if (angle > QUARTER) begin
         fold_val = angle_ext - HALF_EXT;
         fold_neg = 1'b1;
      end else if (angle < NEG_QUARTER) begin
         fold_val = angle_ext + HALF_EXT;
         fold_neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]   <= ertu_pkg::CORDIC_INIT;
         y_ff[0]   <= '0;
         z_ff[0]   <= {{PAD_W{fold_val[EXT_W-1]}}, fold_val,
                       {ertu_pkg::ANGLE_SHIFT{1'b0}}};
         neg_ff[0] <= fold_neg;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [RESID_W-1:0] ATAN_STEP =
         $signed({{(RESID_W-ertu_pkg::ATAN_W){1'b0}}, ertu_pkg::ATAN_TABLE[i]});

      logic signed [TRIG_W-1:0] x_shift;
      logic signed [TRIG_W-1:0] y_shift;

      assign x_shift = x_ff[i] >>> i;
      assign y_shift = y_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (enable) begin
            if (!z_ff[i][RESID_W-1]) begin
               x_ff[i+1] <= x_ff[i] - y_shift;
               y_ff[i+1] <= y_ff[i] + x_shift;
               z_ff[i+1] <= z_ff[i] - ATAN_STEP;
            end else begin
               x_ff[i+1] <= x_ff[i] + y_shift;
               y_ff[i+1] <= y_ff[i] - x_shift;
               z_ff[i+1] <= z_ff[i] + ATAN_STEP;
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (neg_ff[STAGES]) begin
            trig_ff.sin_val <= -y_ff[STAGES];
            trig_ff.cos_val <= -x_ff[STAGES];
         end else begin
            trig_ff.sin_val <= y_ff[STAGES];
            trig_ff.cos_val <= x_ff[STAGES];
         end
      end
   end

   assign trig = trig_ff;

endmodule

`default_nettype wire

// ----- rtl/ertu_rotate.sv -----
// ----------------------------------------------------------------------------
// ertu_rotate
// Plane rotation of a coordinate pair by a Q2.30 sine and cosine:
// a' = a*c - b*s, b' = a*s + b*c, rounded half up. Products in the first
// stage, sums and rounding in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module ertu_rotate (
   input  wire                                     clock,
   input  wire                                     enable,
   input  wire signed [ertu_pkg::COORD_W-1:0]      coord_a,
   input  wire signed [ertu_pkg::COORD_W-1:0]      coord_b,
   input  wire ertu_pkg::ertu_trig_type            trig,
   output logic signed [ertu_pkg::COORD_W-1:0]     rot_a,
   output logic signed [ertu_pkg::COORD_W-1:0]     rot_b
);

   localparam int COORD_W   = ertu_pkg::COORD_W;
   localparam int TRIG_W    = ertu_pkg::TRIG_W;
   localparam int TRIG_FRAC = ertu_pkg::TRIG_FRAC;
   localparam int PROD_W    = COORD_W + TRIG_W;
   localparam int SUM_W     = PROD_W + 1;

   localparam logic signed [SUM_W-1:0] ROUND_HALF =
      {{(SUM_W-TRIG_FRAC){1'b0}}, 1'b1, {(TRIG_FRAC-1){1'b0}}};

   logic signed [TRIG_W-1:0]  sin_v;
   logic signed [TRIG_W-1:0]  cos_v;
   logic signed [PROD_W-1:0]  ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [SUM_W-1:0]   sum_a, sum_b;
   logic signed [COORD_W-1:0] rot_a_ff, rot_b_ff;

   assign sin_v = trig.sin_val;
   assign cos_v = trig.cos_val;

   always_ff @(posedge clock) begin
      if (enable) begin
         ac_ff <= coord_a * cos_v;
         bs_ff <= coord_b * sin_v;
         as_ff <= coord_a * sin_v;
         bc_ff <= coord_b * cos_v;
      end
   end

   assign sum_a = {ac_ff[PROD_W-1], ac_ff} - {bs_ff[PROD_W-1], bs_ff} + ROUND_HALF;
   assign sum_b = {as_ff[PROD_W-1], as_ff} + {bc_ff[PROD_W-1], bc_ff} + ROUND_HALF;

   // The rotated value always fits the coordinate width, so the bits above
   // the selected field are only sign copies.
   always_ff @(posedge clock) begin
      if (enable) begin
         rot_a_ff <= sum_a[TRIG_FRAC +: COORD_W];
         rot_b_ff <= sum_b[TRIG_FRAC +: COORD_W];
      end
   end

   assign rot_a = rot_a_ff;
   assign rot_b = rot_b_ff;

endmodule

`default_nettype wire

// ----- rtl/euler_rotate_translate_unit.sv -----
// ----------------------------------------------------------------------------
// euler_rotate_translate_unit
// Rigid pose transform of a Q16.16 point: yaw about Z, pitch about Y, roll
// about X, then translation and saturation to the 32-bit range.
// ----------------------------------------------------------------------------
// One point is taken per clock while req_stall is low, and one result
// leaves per clock while rsp_stall is low. Three unrolled CORDIC pipelines
// (one stage per iteration, plus fold and output stages) run side by side,
// followed by three two-stage plane rotations, a translate-and-saturate
// stage and the output register. A stalled output freezes the pipeline
// behind one skid entry, so req_stall goes high only when a result is held
// and another has arrived behind it, and it drops the cycle after the held
// beat is taken.
`default_nettype none

module euler_rotate_translate_unit #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire ertu_pkg::ertu_req_type req_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output ertu_pkg::ertu_rsp_type    rsp_payload
);

   localparam int CORDIC_LAT = CORDIC_STAGES + 2;
   localparam int ROT_LAT    = 2;
   localparam int COORD_W    = ertu_pkg::COORD_W;
   localparam int IN_W       = ertu_pkg::COORD_IN_W;

   localparam logic signed [IN_W-1:0] SAT_MAX = 32'sh7FFFFFFF;
   localparam logic signed [IN_W-1:0] SAT_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
   } ofs_type;

   typedef struct packed {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
      ofs_type                ofs;
   } side_type;

   function automatic logic signed [COORD_W-1:0] widen(logic [IN_W-1:0] v);
      return {{(COORD_W-IN_W){v[IN_W-1]}}, v};
   endfunction

   function automatic logic signed [IN_W-1:0] sat_add(logic signed [COORD_W-1:0] c,
                                                      logic signed [IN_W-1:0] o);
      logic signed [COORD_W:0] s;
      s = {c[COORD_W-1], c} + {{(COORD_W+1-IN_W){o[IN_W-1]}}, o};
      if (s[COORD_W:IN_W-1] == {(COORD_W-IN_W+2){s[COORD_W]}}) begin
         return s[IN_W-1:0];
      end else if (s[COORD_W]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

   logic adv;
   logic req_take;

   // Side line carrying the point and offsets beside the CORDIC pipelines.
   side_type                side_ff [CORDIC_LAT];
   logic [CORDIC_LAT-1:0]   side_v_ff;

   ertu_pkg::ertu_trig_type yaw_trig, pitch_trig, roll_trig;

   // Yaw step.
   logic signed [COORD_W-1:0] yaw_a, yaw_b;
   logic signed [COORD_W-1:0] yk_ff [ROT_LAT];
   ofs_type                   yofs_ff [ROT_LAT];
   ertu_pkg::ertu_trig_type   ypt_ff [ROT_LAT];
   ertu_pkg::ertu_trig_type   yrt_ff [ROT_LAT];
   logic [ROT_LAT-1:0]        yv_ff;

   // Pitch step.
   logic signed [COORD_W-1:0] pitch_a, pitch_b;
   logic signed [COORD_W-1:0] pk_ff [ROT_LAT];
   ofs_type                   pofs_ff [ROT_LAT];
   ertu_pkg::ertu_trig_type   prt_ff [ROT_LAT];
   logic [ROT_LAT-1:0]        pv_ff;

   // Roll step.
   logic signed [COORD_W-1:0] roll_a, roll_b;
   logic signed [COORD_W-1:0] rk_ff [ROT_LAT];
   ofs_type                   rofs_ff [ROT_LAT];
   logic [ROT_LAT-1:0]        rv_ff;

   ertu_pkg::ertu_rsp_type    sum_ff;
   logic                      sum_v_ff;

   ertu_pkg::ertu_rsp_type    rsp_ff;
   logic                      rsp_v_ff;
   ertu_pkg::ertu_rsp_type    skid_ff;
   logic                      skid_v_ff;
   logic                      rsp_free;

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;
   assign req_take  = req_valid && !req_stall;

   // ---------------------------------------------------------------- CORDIC
   ertu_cordic #(.STAGES(CORDIC_STAGES)) u_yaw_cordic (
      .clock  (clock),
      .enable (adv),
      .angle  (req_payload.yaw_angle),
      .trig   (yaw_trig)
   );

   ertu_cordic #(.STAGES(CORDIC_STAGES)) u_pitch_cordic (
      .clock  (clock),
      .enable (adv),
      .angle  (req_payload.pitch_angle),
      .trig   (pitch_trig)
   );

   ertu_cordic #(.STAGES(CORDIC_STAGES)) u_roll_cordic (
      .clock  (clock),
      .enable (adv),
      .angle  (req_payload.roll_angle),
      .trig   (roll_trig)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         side_v_ff <= '0;
      end else if (adv) begin
         side_v_ff <= {side_v_ff[CORDIC_LAT-2:0], req_take};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0].x     <= req_payload.point_x;
         side_ff[0].y     <= req_payload.point_y;
         side_ff[0].z     <= req_payload.point_z;
         side_ff[0].ofs.x <= req_payload.offset_x;
         side_ff[0].ofs.y <= req_payload.offset_y;
         side_ff[0].ofs.z <= req_payload.offset_z;
         for (int k = 1; k < CORDIC_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------ yaw about Z
   ertu_rotate u_yaw_rot (
      .clock   (clock),
      .enable  (adv),
      .coord_a (widen(side_ff[CORDIC_LAT-1].x)),
      .coord_b (widen(side_ff[CORDIC_LAT-1].y)),
      .trig    (yaw_trig),
      .rot_a   (yaw_a),
      .rot_b   (yaw_b)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         yk_ff[0]   <= widen(side_ff[CORDIC_LAT-1].z);
         yofs_ff[0] <= side_ff[CORDIC_LAT-1].ofs;
         ypt_ff[0]  <= pitch_trig;
         yrt_ff[0]  <= roll_trig;
         yk_ff[1]   <= yk_ff[0];
         yofs_ff[1] <= yofs_ff[0];
         ypt_ff[1]  <= ypt_ff[0];
         yrt_ff[1]  <= yrt_ff[0];
      end
   end

   // ---------------------------------------------------------- pitch about Y
   // With a = z and b = x the pitch matrix takes the same form as yaw.
   ertu_rotate u_pitch_rot (
      .clock   (clock),
      .enable  (adv),
      .coord_a (yk_ff[ROT_LAT-1]),
      .coord_b (yaw_a),
      .trig    (ypt_ff[ROT_LAT-1]),
      .rot_a   (pitch_a),
      .rot_b   (pitch_b)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         pk_ff[0]   <= yaw_b;
         pofs_ff[0] <= yofs_ff[ROT_LAT-1];
         prt_ff[0]  <= yrt_ff[ROT_LAT-1];
         pk_ff[1]   <= pk_ff[0];
         pofs_ff[1] <= pofs_ff[0];
         prt_ff[1]  <= prt_ff[0];
      end
   end

   // ----------------------------------------------------------- roll about X
   ertu_rotate u_roll_rot (
      .clock   (clock),
      .enable  (adv),
      .coord_a (pk_ff[ROT_LAT-1]),
      .coord_b (pitch_a),
      .trig    (prt_ff[ROT_LAT-1]),
      .rot_a   (roll_a),
      .rot_b   (roll_b)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         rk_ff[0]   <= pitch_b;
         rofs_ff[0] <= pofs_ff[ROT_LAT-1];
         rk_ff[1]   <= rk_ff[0];
         rofs_ff[1] <= rofs_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yv_ff <= '0;
         pv_ff <= '0;
         rv_ff <= '0;
      end else if (adv) begin
         yv_ff <= {yv_ff[0], side_v_ff[CORDIC_LAT-1]};
         pv_ff <= {pv_ff[0], yv_ff[ROT_LAT-1]};
         rv_ff <= {rv_ff[0], pv_ff[ROT_LAT-1]};
      end
   end

   // ------------------------------------------------- translate and saturate
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff.out_x <= sat_add(rk_ff[ROT_LAT-1], rofs_ff[ROT_LAT-1].x);
         sum_ff.out_y <= sat_add(roll_a, rofs_ff[ROT_LAT-1].y);
         sum_ff.out_z <= sat_add(roll_b, rofs_ff[ROT_LAT-1].z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_v_ff <= 1'b0;
      end else if (adv) begin
         sum_v_ff <= rv_ff[ROT_LAT-1];
      end
   end

   // ------------------------------------------------ output register and skid
   // A beat leaving the pipeline while the output is held lands in the skid
   // entry; the pipeline then freezes until the output is taken.
   assign rsp_free = !rsp_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (rsp_free) begin
         if (skid_v_ff) begin
            rsp_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            rsp_v_ff  <= sum_v_ff;
         end
      end else if (sum_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (skid_v_ff) begin
            rsp_ff <= skid_ff;
         end else begin
            rsp_ff <= sum_ff;
         end
      end else if (adv) begin
         skid_ff <= sum_ff;
      end
   end

   assign rsp_valid   = rsp_v_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/ertu_checker.sv -----
// ----------------------------------------------------------------------------
// ertu_checker
// Port-level checks of the pose transform unit's output register and skid
// entry, attached to the top level by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ertu_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_stall,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire ertu_pkg::ertu_rsp_type  rsp_payload
);

   // The skid entry can only be full behind a held result.
   `ERTU_ASSERT(a_stall_needs_held_rsp, req_stall |-> rsp_valid, "stall without held result")

   // The skid entry fills only in a cycle in which the output was held.
   `ERTU_ASSERT(a_stall_after_hold,
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall),
      "skid filled without a held result")

   // Once the held beat is taken, the skid entry is empty in the next cycle.
   `ERTU_ASSERT(a_skid_drains,
      req_stall && !rsp_stall |=> !req_stall,
      "skid entry did not drain")

   // A held result stays and keeps its value.
   `ERTU_ASSERT(a_rsp_holds,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload),
      "held result changed")

   // Reset empties the output register and the skid entry.
   `ERTU_ASSERT_RST(a_reset_clears,
      reset |=> !rsp_valid && !req_stall,
      "reset did not clear output")

endmodule

bind euler_rotate_translate_unit ertu_checker u_ertu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
